@@ rtl/mau_pkg.sv @@
// Shared types and constants for the modular arithmetic unit.
// No dependencies; used by modular_arithmetic_unit_core and mau_modred.
package mau_pkg;

   localparam int unsigned RES_W   = 31;
   localparam int unsigned RED_BITS = 64;
   localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

   typedef enum logic [2:0] {
      OP_REDUCE   = 3'd0,
      OP_ADD      = 3'd1,
      OP_SUB      = 3'd2,
      OP_NEGATE   = 3'd3,
      OP_MULTIPLY = 3'd4,
      OP_POWER    = 3'd5,
      OP_INVERSE  = 3'd6,
      OP_DIVIDE   = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_RED_SUM,
      ST_POW,
      ST_MUL,
      ST_MUL_LOAD,
      ST_MUL_RED,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SEL_PLAIN,
      SEL_DIV,
      SEL_ACC,
      SEL_BASE
   } mul_sel_type;

   typedef struct packed {
      logic        done;
      logic [30:0] remainder;
   } red_status_type;

endpackage

@@ rtl/modular_arithmetic_unit_core.sv @@
// Top level of the modular arithmetic unit: sequencer, operand registers,
// shared multiplier and one mau_modred reducer. Uses mau_pkg.
//
// Usage:
//   req channel: tuser = opcode, tdata = operand_a (signed) then operand_b.
//   rsp channel: tdata = result residue, tuser = inverse-of-zero flag.
//   csr channel: writes the 31-bit modulus; a value of 0 acts as 1. Write it
//   only while no request is in flight.
//   One request at a time: req_tready is high only while the sequencer idles.
//   Every request reduces operand_a, then operand_b; add and sub then reduce
//   the sum once more, and multiply forms one modular product. Power, inverse and divide
//   run one square-and-multiply round per exponent bit; each modular product
//   is a multiply, a load and a reduction, and a round is a square, preceded
//   by a multiply into the accumulator when the bit is set; divide adds one
//   product to inverse. The reducer works one remainder bit per cycle.
//   The result sits in an output register; the next request is taken while it
//   waits, and a stalled receiver holds the sequencer only at its final step.
//   Reset clears the sequencer and output valid and loads modulus 1000000007.
module modular_arithmetic_unit_core #(
   parameter int unsigned EXPONENT_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] operand_a, [127:64] operand_b
   input  logic [2:0]   req_tuser,   // [2:0] opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [30:0] result, [31] zero
   output logic [0:0]   rsp_tuser,   // [0] inverse_of_zero
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [30:0]  csr_wdata
);
   localparam int unsigned EXP_W = (EXPONENT_BITS > 31) ? EXPONENT_BITS : 31;

   mau_pkg::state_type      state_ff, state_in;
   mau_pkg::op_type         opcode_ff, opcode_in;
   mau_pkg::mul_sel_type    msel_ff, msel_in;
   logic [30:0]             modulus_ff;
   logic [63:0]             a_raw_ff, a_raw_in, b_raw_ff, b_raw_in;
   logic [30:0]             a_ff, a_in, b_ff, b_in;
   logic [30:0]             base_ff, base_in, acc_ff, acc_in, res_ff, res_in;
   logic [EXP_W-1:0]        exp_ff, exp_in;
   logic [61:0]             prod_ff, prod_in;
   logic                    flag_ff, flag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [30:0]             rsp_res_ff, rsp_res_in;
   logic                    rsp_flag_ff, rsp_flag_in;

   logic [30:0]             m_eff, one_mod;
   logic [63:0]             req_a, req_mag;
   logic                    red_start;
   logic [63:0]             red_value;
   mau_pkg::red_status_type red_status;
   logic [30:0]             mul_x, mul_y;

   assign m_eff   = (modulus_ff == '0) ? 31'd1 : modulus_ff;
   assign one_mod = (m_eff == 31'd1) ? 31'd0 : 31'd1;
   assign req_a   = req_tdata[63:0];
   assign req_mag = req_a[63] ? (~req_a + 64'd1) : req_a;

   mau_modred u_red (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .value   (red_value),
      .modulus (m_eff),
      .status  (red_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mau_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= mau_pkg::MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            modulus_ff <= csr_wdata;
         end
      end
      opcode_ff   <= opcode_in;
      msel_ff     <= msel_in;
      a_raw_ff    <= a_raw_in;
      b_raw_ff    <= b_raw_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      exp_ff      <= exp_in;
      prod_ff     <= prod_in;
      flag_ff     <= flag_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   always_comb begin
      unique case (msel_ff)
         mau_pkg::SEL_PLAIN: begin mul_x = a_ff;    mul_y = b_ff;    end
         mau_pkg::SEL_DIV:   begin mul_x = a_ff;    mul_y = acc_ff;  end
         mau_pkg::SEL_ACC:   begin mul_x = acc_ff;  mul_y = base_ff; end
         default:            begin mul_x = base_ff; mul_y = base_ff; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      opcode_in    = opcode_ff;
      msel_in      = msel_ff;
      a_raw_in     = a_raw_ff;
      b_raw_in     = b_raw_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      exp_in       = exp_ff;
      prod_in      = prod_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_flag_in  = rsp_flag_ff;
      red_start    = 1'b0;
      red_value    = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mau_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               opcode_in = mau_pkg::op_type'(req_tuser);
               a_raw_in  = req_a;
               b_raw_in  = req_tdata[127:64];
               flag_in   = 1'b0;
               red_start = 1'b1;
               red_value = req_mag;
               state_in  = mau_pkg::ST_RED_A;
            end
         end
         mau_pkg::ST_RED_A: begin
            if (red_status.done) begin
               // fold the sign back in: a negative value maps to m - |a| mod m
               if (a_raw_ff[63] && (red_status.remainder != '0)) begin
                  a_in = m_eff - red_status.remainder;
               end else begin
                  a_in = red_status.remainder;
               end
               red_start = 1'b1;
               red_value = b_raw_ff;
               state_in  = mau_pkg::ST_RED_B;
            end
         end
         mau_pkg::ST_RED_B: begin
            if (red_status.done) begin
               b_in     = red_status.remainder;
               state_in = mau_pkg::ST_DISPATCH;
            end
         end
         mau_pkg::ST_DISPATCH: begin
            unique case (opcode_ff)
               mau_pkg::OP_REDUCE: begin
                  res_in   = a_ff;
                  state_in = mau_pkg::ST_FINISH;
               end
               mau_pkg::OP_ADD: begin
                  red_start = 1'b1;
                  red_value = 64'({1'b0, a_ff} + {1'b0, b_ff});
                  state_in  = mau_pkg::ST_RED_SUM;
               end
               mau_pkg::OP_SUB: begin
                  red_start = 1'b1;
                  red_value = 64'({1'b0, a_ff} + {1'b0, m_eff} - {1'b0, b_ff});
                  state_in  = mau_pkg::ST_RED_SUM;
               end
               mau_pkg::OP_NEGATE: begin
                  res_in   = (a_ff == '0) ? '0 : (m_eff - a_ff);
                  state_in = mau_pkg::ST_FINISH;
               end
               mau_pkg::OP_MULTIPLY: begin
                  msel_in  = mau_pkg::SEL_PLAIN;
                  state_in = mau_pkg::ST_MUL;
               end
               mau_pkg::OP_POWER: begin
                  base_in  = a_ff;
                  acc_in   = one_mod;
                  exp_in   = EXP_W'(b_raw_ff[EXPONENT_BITS-1:0]);
                  state_in = mau_pkg::ST_POW;
               end
               mau_pkg::OP_INVERSE: begin
                  if (a_ff == '0) begin
                     flag_in  = 1'b1;
                     res_in   = '0;
                     state_in = mau_pkg::ST_FINISH;
                  end else begin
                     base_in  = a_ff;
                     acc_in   = one_mod;
                     exp_in   = EXP_W'(m_eff - 31'd2);
                     state_in = mau_pkg::ST_POW;
                  end
               end
               default: begin
                  if (b_ff == '0) begin
                     flag_in  = 1'b1;
                     res_in   = '0;
                     state_in = mau_pkg::ST_FINISH;
                  end else begin
                     base_in  = b_ff;
                     acc_in   = one_mod;
                     exp_in   = EXP_W'(m_eff - 31'd2);
                     state_in = mau_pkg::ST_POW;
                  end
               end
            endcase
         end
         mau_pkg::ST_RED_SUM: begin
            if (red_status.done) begin
               res_in   = red_status.remainder;
               state_in = mau_pkg::ST_FINISH;
            end
         end
         mau_pkg::ST_POW: begin
            priority if (exp_ff == '0) begin
               if (opcode_ff == mau_pkg::OP_DIVIDE) begin
                  msel_in  = mau_pkg::SEL_DIV;
                  state_in = mau_pkg::ST_MUL;
               end else begin
                  res_in   = acc_ff;
                  state_in = mau_pkg::ST_FINISH;
               end
            end else if (exp_ff[0]) begin
               msel_in  = mau_pkg::SEL_ACC;
               state_in = mau_pkg::ST_MUL;
            end else begin
               msel_in  = mau_pkg::SEL_BASE;
               state_in = mau_pkg::ST_MUL;
            end
         end
         mau_pkg::ST_MUL: begin
            prod_in  = 62'(mul_x) * 62'(mul_y);
            state_in = mau_pkg::ST_MUL_LOAD;
         end
         mau_pkg::ST_MUL_LOAD: begin
            red_start = 1'b1;
            red_value = 64'(prod_ff);
            state_in  = mau_pkg::ST_MUL_RED;
         end
         mau_pkg::ST_MUL_RED: begin
            if (red_status.done) begin
               unique case (msel_ff)
                  mau_pkg::SEL_ACC: begin
                     acc_in   = red_status.remainder;
                     msel_in  = mau_pkg::SEL_BASE;
                     state_in = mau_pkg::ST_MUL;
                  end
                  mau_pkg::SEL_BASE: begin
                     base_in  = red_status.remainder;
                     exp_in   = exp_ff >> 1;
                     state_in = mau_pkg::ST_POW;
                  end
                  default: begin
                     res_in   = red_status.remainder;
                     state_in = mau_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         default: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_flag_in  = flag_ff;
               state_in     = mau_pkg::ST_IDLE;
            end
         end
      endcase
   end

   assign req_tready = (state_ff == mau_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_res_ff};
   assign rsp_tuser  = rsp_flag_ff;

endmodule

@@ rtl/mau_modred.sv @@
// Bit-serial restoring reducer: 64-bit value mod a 31-bit modulus.
// One bit per cycle; done pulses once all 64 bits are shifted in. Uses mau_pkg.
module mau_modred (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             value,
   input  logic [30:0]             modulus,
   output mau_pkg::red_status_type status
);
   localparam int unsigned CNT_W = $clog2(mau_pkg::RED_BITS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [63:0]       val_ff, val_in;
   logic [30:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff, val_ff[63]};
      if (start) begin
         busy_in = 1'b1;
         val_in  = value;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         // shift in the next bit, subtract once if it overflows the modulus
         if (trial >= {1'b0, modulus}) begin
            rem_in = 31'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[30:0];
         end
         val_in = {val_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(mau_pkg::RED_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

@@ rtl/mau_checker.sv @@
// Port-level checks for modular_arithmetic_unit_core, bound to the top level.
// Depends only on the top level's ports.
module mau_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a request is in flight");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[30:0] == 31'd0)
      else $error("zero-divisor response carries a nonzero residue");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("padding bit set");
endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
